/* rtl/msseq_pkg.sv */
// Shared types, codes, reset values and lookup tables of the melody score sequencer.
package msseq_pkg;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_RESTART = 3'd1;
  localparam logic [2:0] CMD_PLAY    = 3'd2;
  localparam logic [2:0] CMD_SLOWER  = 3'd3;
  localparam logic [2:0] CMD_FASTER  = 3'd4;
  localparam logic [2:0] CMD_SELECT  = 3'd5;
  localparam logic [2:0] CMD_LOAD    = 3'd6;

  localparam logic [1:0] MODE_PLAYING = 2'd0;
  localparam logic [1:0] MODE_PAUSED  = 2'd1;
  localparam logic [1:0] MODE_READY   = 2'd2;
  localparam logic [1:0] MODE_ENDED   = 2'd3;

  localparam logic [2:0] REG_SONG0_START = 3'd0;
  localparam logic [2:0] REG_SONG0_LEN   = 3'd1;
  localparam logic [2:0] REG_SONG1_START = 3'd2;
  localparam logic [2:0] REG_SONG1_LEN   = 3'd3;
  localparam logic [2:0] REG_TEMPO       = 3'd4;
  localparam logic [2:0] REG_BLINK       = 3'd5;

  localparam logic [8:0]  RST_SONG0_START = 9'd0;
  localparam logic [9:0]  RST_SONG0_LEN   = 10'd72;
  localparam logic [8:0]  RST_SONG1_START = 9'd72;
  localparam logic [9:0]  RST_SONG1_LEN   = 10'd418;
  localparam logic [6:0]  RST_TEMPO       = 7'd18;
  localparam logic [5:0]  RST_BLINK       = 6'd30;
  localparam logic [10:0] RST_PERIOD      = 11'd1;

  localparam logic [6:0]  TEMPO_SLOW_LIMIT = 7'd80;
  localparam logic [6:0]  TEMPO_FLOOR      = 7'd1;
  localparam logic [10:0] TICK_MAX         = 11'd2047;

  typedef struct packed {
    logic [7:0] load_value;
    logic [8:0] load_address;
    logic       song_choice;
    logic [2:0] cmd;
  } item_t;

  typedef struct packed {
    logic [9:0]  position;
    logic        led_level;
    logic [10:0] half_period;
    logic        tone_enable;
    logic [1:0]  mode;
  } result_t;

  typedef struct packed {
    logic [8:0] song0_start;
    logic [9:0] song0_len;
    logic [8:0] song1_start;
    logic [9:0] song1_len;
    logic [6:0] tempo;
    logic [5:0] blink;
  } cfg_t;

  function automatic logic [6:0] class_units(input logic [2:0] cls);
    logic [6:0] u;
    unique case (cls)
      3'd0:    u = 7'd1;
      3'd1:    u = 7'd8;
      3'd2:    u = 7'd16;
      3'd3:    u = 7'd24;
      3'd4:    u = 7'd32;
      3'd5:    u = 7'd48;
      3'd6:    u = 7'd64;
      3'd7:    u = 7'd96;
      default: u = 7'd1;
    endcase
    return u;
  endfunction

  // index 0 is a rest; anything past the table also reads as a rest
  function automatic logic [10:0] half_period_of(input logic [4:0] n);
    logic [10:0] p;
    case (n)
      5'd1:    p = 11'd1911;
      5'd2:    p = 11'd1803;
      5'd3:    p = 11'd1703;
      5'd4:    p = 11'd1607;
      5'd5:    p = 11'd1517;
      5'd6:    p = 11'd1432;
      5'd7:    p = 11'd1351;
      5'd8:    p = 11'd1276;
      5'd9:    p = 11'd1204;
      5'd10:   p = 11'd1136;
      5'd11:   p = 11'd1073;
      5'd12:   p = 11'd1012;
      5'd13:   p = 11'd956;
      5'd14:   p = 11'd902;
      5'd15:   p = 11'd851;
      5'd16:   p = 11'd803;
      5'd17:   p = 11'd758;
      5'd18:   p = 11'd716;
      5'd19:   p = 11'd676;
      5'd20:   p = 11'd638;
      5'd21:   p = 11'd602;
      5'd22:   p = 11'd568;
      5'd23:   p = 11'd536;
      5'd24:   p = 11'd506;
      5'd25:   p = 11'd478;
      default: p = 11'd1;
    endcase
    return p;
  endfunction

endpackage

/* rtl/msseq_cfg_regs.sv */
// APB configuration register file of the melody score sequencer.
module msseq_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output msseq_pkg::cfg_t     cfg
);

  msseq_pkg::cfg_t cfg_r;
  logic            wr_en;
  logic [2:0]      idx;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.song0_start <= msseq_pkg::RST_SONG0_START;
      cfg_r.song0_len   <= msseq_pkg::RST_SONG0_LEN;
      cfg_r.song1_start <= msseq_pkg::RST_SONG1_START;
      cfg_r.song1_len   <= msseq_pkg::RST_SONG1_LEN;
      cfg_r.tempo       <= msseq_pkg::RST_TEMPO;
      cfg_r.blink       <= msseq_pkg::RST_BLINK;
    end else if (wr_en) begin
      case (idx)
        msseq_pkg::REG_SONG0_START: cfg_r.song0_start <= pwdata[8:0];
        msseq_pkg::REG_SONG0_LEN:   cfg_r.song0_len   <= pwdata[9:0];
        msseq_pkg::REG_SONG1_START: cfg_r.song1_start <= pwdata[8:0];
        msseq_pkg::REG_SONG1_LEN:   cfg_r.song1_len   <= pwdata[9:0];
        msseq_pkg::REG_TEMPO:       cfg_r.tempo       <= pwdata[6:0];
        msseq_pkg::REG_BLINK:       cfg_r.blink       <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      msseq_pkg::REG_SONG0_START: prdata = 32'(cfg_r.song0_start);
      msseq_pkg::REG_SONG0_LEN:   prdata = 32'(cfg_r.song0_len);
      msseq_pkg::REG_SONG1_START: prdata = 32'(cfg_r.song1_start);
      msseq_pkg::REG_SONG1_LEN:   prdata = 32'(cfg_r.song1_len);
      msseq_pkg::REG_TEMPO:       prdata = 32'(cfg_r.tempo);
      msseq_pkg::REG_BLINK:       prdata = 32'(cfg_r.blink);
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/msseq_score_mem.sv */
// Score byte memory: one write port, one registered read port.
module msseq_score_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* rtl/msseq_core.sv */
// Player state and per-command update; forms score read and write addresses.
module msseq_core #(
  parameter int AW         = 9,
  parameter int NOTE_COUNT = 26
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msseq_pkg::cfg_t      cfg,
  input  msseq_pkg::item_t     in_item,
  output logic [AW-1:0]        rd_addr,
  input  logic [7:0]           rd_data,
  input  msseq_pkg::item_t     s1_item,
  input  logic                 s1_fire,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data,
  output msseq_pkg::result_t   result_nxt
);

  localparam int SW = (AW > 11) ? AW : 11;

  logic [8:0]  base_r,   base_nxt;
  logic [9:0]  len_r,    len_nxt;
  logic [9:0]  idx_r,    idx_nxt;
  logic [10:0] tick_r,   tick_nxt;
  logic [6:0]  tempo_r,  tempo_nxt;
  logic        brk_r,    brk_nxt;
  logic [1:0]  mode_r,   mode_nxt;
  logic [5:0]  blink_r,  blink_nxt;
  logic        led_r,    led_nxt;
  logic        tone_r,   tone_nxt;
  logic [10:0] period_r, period_nxt;
  logic [7:0]  cur_r,    cur_nxt;

  logic [SW-1:0] next_sum, cur_sum, sel_sum, ld_sum, base_sum;
  logic [8:0]    sel_base;
  logic [9:0]    idx_inc;
  logic [13:0]   need, have;
  logic [10:0]   rd_period;
  logic [AW-1:0] cur_addr;

  assign idx_inc  = idx_r + 10'd1;
  assign next_sum = SW'(base_r) + SW'(idx_inc);
  assign cur_sum  = SW'(base_r) + SW'(idx_r);
  assign base_sum = SW'(base_r);
  assign sel_base = in_item.song_choice ? cfg.song1_start : cfg.song0_start;
  assign sel_sum  = SW'(sel_base);
  assign ld_sum   = SW'(s1_item.load_address);
  assign cur_addr = cur_sum[AW-1:0];

  always_comb begin
    unique case (in_item.cmd)
      msseq_pkg::CMD_RESTART: rd_addr = base_sum[AW-1:0];
      msseq_pkg::CMD_SELECT:  rd_addr = sel_sum[AW-1:0];
      default:                rd_addr = next_sum[AW-1:0];
    endcase
  end

  assign wr_en   = s1_fire && (s1_item.cmd == msseq_pkg::CMD_LOAD);
  assign wr_addr = ld_sum[AW-1:0];
  assign wr_data = s1_item.load_value;

  assign need = 14'(msseq_pkg::class_units(cur_r[7:5])) * 14'(tempo_r);
  assign have = {tick_r, 3'b000};
  assign rd_period = (6'(rd_data[4:0]) < 6'(NOTE_COUNT)) ?
                     msseq_pkg::half_period_of(rd_data[4:0]) : msseq_pkg::RST_PERIOD;

  always_comb begin
    base_nxt   = base_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    tick_nxt   = tick_r;
    tempo_nxt  = tempo_r;
    brk_nxt    = brk_r;
    mode_nxt   = mode_r;
    blink_nxt  = blink_r;
    led_nxt    = led_r;
    tone_nxt   = tone_r;
    period_nxt = period_r;
    cur_nxt    = cur_r;
    unique case (s1_item.cmd)
      msseq_pkg::CMD_TICK: begin
        if (mode_r == msseq_pkg::MODE_PLAYING) begin
          if (idx_r < len_r) begin
            if (brk_r || (have >= need)) begin
              tick_nxt = '0;
              idx_nxt  = idx_inc;
              brk_nxt  = 1'b0;
              if (idx_inc < len_r) begin
                period_nxt = rd_period;
                cur_nxt    = rd_data;
                if (!brk_r && (rd_data[7:5] == 3'd0)) begin
                  brk_nxt = 1'b1;
                end
              end
            end else if (tick_r < msseq_pkg::TICK_MAX) begin
              tick_nxt = tick_r + 11'd1;
            end
          end else begin
            mode_nxt = msseq_pkg::MODE_ENDED;
            tone_nxt = 1'b0;
            led_nxt  = 1'b1;
          end
        end else if (mode_r == msseq_pkg::MODE_PAUSED) begin
          if (blink_r == cfg.blink) begin
            blink_nxt = '0;
            led_nxt   = ~led_r;
          end else begin
            blink_nxt = blink_r + 6'd1;
          end
        end
      end
      msseq_pkg::CMD_RESTART, msseq_pkg::CMD_SELECT: begin
        if (s1_item.cmd == msseq_pkg::CMD_SELECT) begin
          base_nxt = s1_item.song_choice ? cfg.song1_start : cfg.song0_start;
          len_nxt  = s1_item.song_choice ? cfg.song1_len : cfg.song0_len;
        end
        tone_nxt   = 1'b0;
        tick_nxt   = '0;
        idx_nxt    = '0;
        tempo_nxt  = cfg.tempo;
        brk_nxt    = 1'b0;
        mode_nxt   = msseq_pkg::MODE_READY;
        period_nxt = rd_period;
        cur_nxt    = rd_data;
        led_nxt    = 1'b1;
      end
      msseq_pkg::CMD_PLAY: begin
        if (mode_r != msseq_pkg::MODE_ENDED) begin
          tone_nxt = ~tone_r;
          if (mode_r == msseq_pkg::MODE_PLAYING) begin
            mode_nxt = msseq_pkg::MODE_PAUSED;
          end else begin
            mode_nxt = msseq_pkg::MODE_PLAYING;
            led_nxt  = 1'b0;
          end
        end
      end
      msseq_pkg::CMD_SLOWER: begin
        if (tempo_r < msseq_pkg::TEMPO_SLOW_LIMIT) begin
          tempo_nxt = tempo_r + 7'd1;
        end
      end
      msseq_pkg::CMD_FASTER: begin
        if (tempo_r > msseq_pkg::TEMPO_FLOOR) begin
          tempo_nxt = tempo_r - 7'd1;
        end
      end
      msseq_pkg::CMD_LOAD: begin
        // keep the cached current note in step with the memory
        if (wr_addr == cur_addr) begin
          cur_nxt = s1_item.load_value;
        end
      end
      default: ;
    endcase
  end

  assign result_nxt.mode        = mode_nxt;
  assign result_nxt.tone_enable = tone_nxt;
  assign result_nxt.half_period = period_nxt;
  assign result_nxt.led_level   = led_nxt;
  assign result_nxt.position    = idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= msseq_pkg::RST_SONG0_START;
      len_r    <= msseq_pkg::RST_SONG0_LEN;
      idx_r    <= '0;
      tick_r   <= '0;
      tempo_r  <= msseq_pkg::RST_TEMPO;
      brk_r    <= 1'b0;
      mode_r   <= msseq_pkg::MODE_READY;
      blink_r  <= '0;
      led_r    <= 1'b1;
      tone_r   <= 1'b0;
      period_r <= msseq_pkg::RST_PERIOD;
    end else if (s1_fire) begin
      base_r   <= base_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      tick_r   <= tick_nxt;
      tempo_r  <= tempo_nxt;
      brk_r    <= brk_nxt;
      mode_r   <= mode_nxt;
      blink_r  <= blink_nxt;
      led_r    <= led_nxt;
      tone_r   <= tone_nxt;
      period_r <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      cur_r <= cur_nxt;
    end
  end

endmodule

/* rtl/melody_score_sequencer.sv */
// The score byte is read into the memory read register when an item is accepted; the state
// update and the output register load follow when the held item fires, which waits while the
// output stalls. in_tready is low while an accepted item is held, until its update fires.
// An item may be accepted while the previous result still waits on the output register.
// Reset (rst_n low, synchronous) clears control state and loads register reset values;
// the score memory is not cleared and holds undefined bytes until written.
module melody_score_sequencer #(
  parameter int SCORE_DEPTH = 512,
  parameter int NOTE_COUNT  = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd[2:0], load_address[11:3], load_value[19:12], zero pad
  input  logic [0:0]  in_tuser,   // song_choice[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // mode[1:0], tone_enable[2], half_period[13:3],
                                  // led_level[14], position[24:15], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = $clog2(SCORE_DEPTH);

  msseq_pkg::cfg_t    cfg;
  msseq_pkg::item_t   in_item;
  msseq_pkg::item_t   s1_item_r;
  msseq_pkg::result_t result_nxt;
  msseq_pkg::result_t out_r;

  logic          s1_valid_r;
  logic          out_valid_r;
  logic          accept;
  logic          s1_fire;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  assign in_item.cmd          = in_tdata[2:0];
  assign in_item.load_address = in_tdata[11:3];
  assign in_item.load_value   = in_tdata[19:12];
  assign in_item.song_choice  = in_tuser[0];

  assign in_tready  = !s1_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign s1_fire    = s1_valid_r && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.position, out_r.led_level, out_r.half_period,
                       out_r.tone_enable, out_r.mode};
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
    if (s1_fire) begin
      out_r <= result_nxt;
    end
  end

  msseq_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  msseq_score_mem #(
    .DEPTH (SCORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  msseq_core #(
    .AW         (AW),
    .NOTE_COUNT (NOTE_COUNT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_item    (in_item),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .s1_item    (s1_item_r),
    .s1_fire    (s1_fire),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .result_nxt (result_nxt)
  );

endmodule
